// ----- design/mrd_pkg.sv -----
`timescale 1ns / 1ps

package mrd_pkg;

  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  WRITE_ECHO_LEFT = 8'd3;
  localparam int          EXC_BIT         = 7;

  // Reset values of the configuration registers.
  localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd1;
  localparam logic [3:0] READ_CODE_RST      = 4'd3;
  localparam logic [3:0] WRITE_CODE_RST     = 4'd6;

  typedef enum logic [1:0] {
    CFG_DEVICE_ADDRESS = 2'd0,
    CFG_READ_CODE      = 2'd1,
    CFG_WRITE_CODE     = 2'd2
  } cfg_index_t;

  // Numeric frame state codes as reported on the result channel.
  localparam logic [3:0] FS_WAIT         = 4'd0;
  localparam logic [3:0] FS_ADDR         = 4'd1;
  localparam logic [3:0] FS_EXC_FUNC     = 4'd2;
  localparam logic [3:0] FS_EXC_CODE     = 4'd3;
  localparam logic [3:0] FS_READ_FUNC    = 4'd4;
  localparam logic [3:0] FS_WRITE_FUNC   = 4'd5;
  localparam logic [3:0] FS_PAYLOAD      = 4'd6;
  localparam logic [3:0] FS_LAST_PAYLOAD = 4'd7;
  localparam logic [3:0] FS_CRC_LOW      = 4'd8;
  localparam logic [3:0] FS_COMPLETE     = 4'd9;

  typedef enum logic [9:0] {
    ST_WAIT         = 10'b00_0000_0001,
    ST_ADDR         = 10'b00_0000_0010,
    ST_EXC_FUNC     = 10'b00_0000_0100,
    ST_EXC_CODE     = 10'b00_0000_1000,
    ST_READ_FUNC    = 10'b00_0001_0000,
    ST_WRITE_FUNC   = 10'b00_0010_0000,
    ST_PAYLOAD      = 10'b00_0100_0000,
    ST_LAST_PAYLOAD = 10'b00_1000_0000,
    ST_CRC_LOW      = 10'b01_0000_0000,
    ST_COMPLETE     = 10'b10_0000_0000
  } parse_state_t;

  typedef struct packed {
    logic [7:0] device_address;
    logic [3:0] read_code;
    logic [3:0] write_code;
  } cfg_t;

  typedef struct packed {
    parse_state_t parse_state;
    logic [7:0]   bytes_left;
    logic [15:0]  running_crc;
    logic [7:0]   crc_low_held;
    logic [8:0]   position_count;
    logic         exception_flag;
  } ctx_t;

  typedef struct packed {
    logic [3:0] frame_state;
    logic [7:0] echo_byte;
    logic [8:0] byte_position;
    logic       is_exception;
    logic       frame_good;
    logic       crc_error;
  } result_t;

  // One byte of CRC-16/MODBUS, reflected, least significant bit first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

  function automatic logic [3:0] state_code(input parse_state_t st);
    logic [3:0] code;
    case (st)
      ST_ADDR:         code = FS_ADDR;
      ST_EXC_FUNC:     code = FS_EXC_FUNC;
      ST_EXC_CODE:     code = FS_EXC_CODE;
      ST_READ_FUNC:    code = FS_READ_FUNC;
      ST_WRITE_FUNC:   code = FS_WRITE_FUNC;
      ST_PAYLOAD:      code = FS_PAYLOAD;
      ST_LAST_PAYLOAD: code = FS_LAST_PAYLOAD;
      ST_CRC_LOW:      code = FS_CRC_LOW;
      ST_COMPLETE:     code = FS_COMPLETE;
      default:         code = FS_WAIT;
    endcase
    return code;
  endfunction

endpackage

// ----- design/mrd_in_if.sv -----
`timescale 1ns / 1ps

interface mrd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- design/mrd_out_if.sv -----
`timescale 1ns / 1ps

interface mrd_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] frame_state;
  logic [7:0] echo_byte;
  logic [8:0] byte_position;
  logic       is_exception;
  logic       frame_good;
  logic       crc_error;

  modport source (output valid, output frame_state, output echo_byte,
                  output byte_position, output is_exception, output frame_good,
                  output crc_error, input ready);
  modport sink   (input valid, input frame_state, input echo_byte,
                  input byte_position, input is_exception, input frame_good,
                  input crc_error, output ready);
endinterface

// ----- design/mrd_core.sv -----
`timescale 1ns / 1ps

module mrd_core import mrd_pkg::*; (
  input  ctx_t       ctx,
  input  cfg_t       cfg,
  input  logic [7:0] rx_byte,
  output ctx_t       ctx_nxt,
  output result_t    res
);

  ctx_t mid;
  logic good;
  logic err;
  logic in_frame;

  always_comb begin
    mid      = ctx;
    good     = 1'b0;
    err      = 1'b0;
    in_frame = 1'b1;
    case (ctx.parse_state)
      ST_ADDR: begin
        mid.running_crc = crc_update(ctx.running_crc, rx_byte);
        if (rx_byte[EXC_BIT]) begin
          mid.parse_state    = ST_EXC_FUNC;
          mid.exception_flag = 1'b1;
        end else if (rx_byte[3:0] == cfg.read_code) begin
          mid.parse_state    = ST_READ_FUNC;
          mid.exception_flag = 1'b0;
        end else if (rx_byte[3:0] == cfg.write_code) begin
          mid.parse_state    = ST_WRITE_FUNC;
          mid.exception_flag = 1'b0;
        end else begin
          mid.parse_state    = ST_WAIT;
          mid.exception_flag = 1'b0;
        end
      end
      ST_EXC_FUNC: begin
        mid.running_crc = crc_update(ctx.running_crc, rx_byte);
        mid.parse_state = ST_EXC_CODE;
      end
      ST_EXC_CODE, ST_LAST_PAYLOAD: begin
        mid.crc_low_held = rx_byte;
        mid.parse_state  = ST_CRC_LOW;
      end
      ST_READ_FUNC: begin
        mid.running_crc = crc_update(ctx.running_crc, rx_byte);
        mid.bytes_left  = rx_byte;
        mid.parse_state = ST_PAYLOAD;
      end
      ST_WRITE_FUNC: begin
        mid.running_crc = crc_update(ctx.running_crc, rx_byte);
        mid.bytes_left  = WRITE_ECHO_LEFT;
        mid.parse_state = ST_PAYLOAD;
      end
      ST_PAYLOAD: begin
        mid.running_crc = crc_update(ctx.running_crc, rx_byte);
        // A count of zero ends the payload just as a count of one does.
        if (ctx.bytes_left <= 8'd1) begin
          mid.bytes_left  = 8'd0;
          mid.parse_state = ST_LAST_PAYLOAD;
        end else begin
          mid.bytes_left = ctx.bytes_left - 8'd1;
        end
      end
      ST_CRC_LOW: begin
        if (ctx.crc_low_held == ctx.running_crc[7:0] &&
            rx_byte == ctx.running_crc[15:8]) begin
          mid.parse_state = ST_COMPLETE;
          good            = 1'b1;
        end else begin
          mid.parse_state = ST_WAIT;
          err             = 1'b1;
        end
      end
      default: begin
        // Waiting or complete: only the address byte opens a frame.
        if (rx_byte == cfg.device_address) begin
          mid.parse_state    = ST_ADDR;
          mid.running_crc    = crc_update(CRC_INIT, rx_byte);
          mid.position_count = 9'd0;
          mid.bytes_left     = 8'd0;
          mid.crc_low_held   = 8'd0;
          mid.exception_flag = 1'b0;
        end else begin
          if (ctx.parse_state != ST_COMPLETE) begin
            mid.parse_state = ST_WAIT;
          end
          in_frame = 1'b0;
        end
      end
    endcase
  end

  always_comb begin
    ctx_nxt = mid;
    if (in_frame) begin
      ctx_nxt.position_count = mid.position_count + 9'd1;
    end
    res.frame_state   = state_code(mid.parse_state);
    res.echo_byte     = rx_byte;
    res.byte_position = in_frame ? mid.position_count : 9'd0;
    res.is_exception  = in_frame & mid.exception_flag;
    res.frame_good    = good;
    res.crc_error     = err;
  end

endmodule

// ----- design/modbus_response_deframer.sv -----
`timescale 1ns / 1ps

// Modbus RTU response deframer. Each request on in_ch carries one received
// byte and produces exactly one result on out_ch giving the frame state after
// that byte, the byte itself, its position in the frame, and the exception,
// good-frame and CRC-error flags. The CRC-16/MODBUS check is updated one byte
// per request, so a byte is taken every clock cycle while out_ch keeps up;
// the result is registered and appears in the cycle after its byte, and the
// single output register lets the next byte in while the previous result is
// being taken. The address, read code and write code registers are written
// through cfg_* and should only be changed while no result is outstanding.
module modbus_response_deframer import mrd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  mrd_in_if.sink     in_ch,
  mrd_out_if.source  out_ch
);

  cfg_t    cfg_r;
  ctx_t    ctx_r;
  ctx_t    ctx_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_valid_r;
  logic    accept;

  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  mrd_core u_core (
    .ctx     (ctx_r),
    .cfg     (cfg_r),
    .rx_byte (in_ch.rx_byte),
    .ctx_nxt (ctx_nxt),
    .res     (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address <= DEVICE_ADDRESS_RST;
      cfg_r.read_code      <= READ_CODE_RST;
      cfg_r.write_code     <= WRITE_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEVICE_ADDRESS: cfg_r.device_address <= cfg_wdata;
        CFG_READ_CODE:      cfg_r.read_code      <= cfg_wdata[3:0];
        CFG_WRITE_CODE:     cfg_r.write_code     <= cfg_wdata[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctx_r.parse_state    <= ST_WAIT;
      ctx_r.bytes_left     <= 8'd0;
      ctx_r.running_crc    <= CRC_INIT;
      ctx_r.crc_low_held   <= 8'd0;
      ctx_r.position_count <= 9'd0;
      ctx_r.exception_flag <= 1'b0;
      out_valid_r          <= 1'b0;
    end else begin
      if (accept) begin
        ctx_r <= ctx_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.frame_state   = res_r.frame_state;
  assign out_ch.echo_byte     = res_r.echo_byte;
  assign out_ch.byte_position = res_r.byte_position;
  assign out_ch.is_exception  = res_r.is_exception;
  assign out_ch.frame_good    = res_r.frame_good;
  assign out_ch.crc_error     = res_r.crc_error;

endmodule
